// ----- hw/rtl/md4_pkg.sv -----
`default_nettype none

package md4_pkg;

    // Front part: taking message bytes, or generating the padding tail.
    typedef enum logic {
        FR_DATA,
        FR_PAD
    } t_front_state;

    // Back part: loading a block, compressing, folding in, emitting.
    typedef enum logic [1:0] {
        BK_FILL,
        BK_RUN,
        BK_ADD,
        BK_EMIT
    } t_back_state;

    // One little-endian block word on its way from the front to the back.
    typedef struct packed {
        logic [31:0] data;
        logic        blk_end;
        logic        digest;
    } t_word_entry;

    // Initial chaining value and round constants.
    localparam logic [31:0] IV_A     = 32'h67452301;
    localparam logic [31:0] IV_B     = 32'hefcdab89;
    localparam logic [31:0] IV_C     = 32'h98badcfe;
    localparam logic [31:0] IV_D     = 32'h10325476;
    localparam logic [31:0] K_ROUND1 = 32'h00000000;
    localparam logic [31:0] K_ROUND2 = 32'h5a827999;
    localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;

    // Round codes, taken from the top bits of the step counter.
    localparam logic [1:0] ROUND_1 = 2'd0;
    localparam logic [1:0] ROUND_2 = 2'd1;

    // Padding and block layout.
    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LEN_START_POS = 6'd56;
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [1:0] LAST_LANE     = 2'd3;
    localparam logic [3:0] LAST_WORD_POS = 4'd15;
    localparam logic [5:0] LAST_STEP     = 6'd47;
    localparam logic [1:0] LAST_DIGEST   = 2'd3;

    // Word queue between the two parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Which buffer word a step reads.
    function automatic logic [3:0] md4_word_idx(input logic [1:0] rnd, input logic [3:0] s);
        logic [3:0] idx;
        case (rnd)
            ROUND_1: idx = s;
            ROUND_2: idx = {s[1:0], s[3:2]};
            default: idx = {s[0], s[1], s[2], s[3]};
        endcase
        return idx;
    endfunction

    // Left rotation amount of a step.
    function automatic logic [4:0] md4_rot(input logic [1:0] rnd, input logic [1:0] sel);
        logic [4:0] amt;
        amt = 5'd3;
        case (rnd)
            ROUND_1: begin
                case (sel)
                    2'd0:    amt = 5'd3;
                    2'd1:    amt = 5'd7;
                    2'd2:    amt = 5'd11;
                    default: amt = 5'd19;
                endcase
            end
            ROUND_2: begin
                case (sel)
                    2'd0:    amt = 5'd3;
                    2'd1:    amt = 5'd5;
                    2'd2:    amt = 5'd9;
                    default: amt = 5'd13;
                endcase
            end
            default: begin
                case (sel)
                    2'd0:    amt = 5'd3;
                    2'd1:    amt = 5'd9;
                    2'd2:    amt = 5'd11;
                    default: amt = 5'd15;
                endcase
            end
        endcase
        return amt;
    endfunction

    // Boolean function of each round.
    function automatic logic [31:0] md4_round_fn(input logic [1:0] rnd, input logic [31:0] b,
                                                 input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (rnd)
            ROUND_1: f = ((c ^ d) & b) ^ d;
            ROUND_2: f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    // Additive constant of each round.
    function automatic logic [31:0] md4_round_k(input logic [1:0] rnd);
        logic [31:0] k;
        case (rnd)
            ROUND_1: k = K_ROUND1;
            ROUND_2: k = K_ROUND2;
            default: k = K_ROUND3;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/md4_if.sv -----
`default_nettype none

// Message channel: one byte or a finish request per word.
interface md4_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] message_byte;

    modport source (output valid, output action, output message_byte, input ready);
    modport sink (input valid, input action, input message_byte, output ready);
endinterface

// Digest channel: one 32-bit digest word per word.
interface md4_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/md4_front.sv -----
`default_nettype none

module md4_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    md4_in_if.sink            i_in,
    input  wire logic         i_full,
    output logic              o_push,
    output md4_pkg::t_word_entry o_entry
);
    import md4_pkg::*;

    t_front_state r_state, n_state;
    logic [5:0]   r_pos;
    logic [63:0]  r_bits;
    logic [63:0]  r_len;
    logic [31:0]  r_word;
    logic         r_first;
    logic         r_len_phase;

    logic         take;
    logic         absorb;
    logic         finish;
    logic         pad_step;
    logic         byte_step;
    logic [7:0]   pad_byte;
    logic [7:0]   byte_val;
    logic [31:0]  word_next;
    logic         last_pad;

    // Handshake and byte selection.
    always_comb begin
        i_in.ready = (r_state == FR_DATA) && !i_full;
        take       = i_in.valid && i_in.ready;
        absorb     = take && !i_in.action;
        finish     = take && i_in.action;
        pad_step   = (r_state == FR_PAD) && !i_full;
        byte_step  = absorb || pad_step;
        if (r_first) begin
            pad_byte = PAD_BYTE;
        end else if (r_len_phase) begin
            pad_byte = r_len[7:0];
        end else begin
            pad_byte = 8'h00;
        end
        byte_val  = absorb ? i_in.message_byte : pad_byte;
        word_next = {byte_val, r_word[31:8]};
        last_pad  = pad_step && r_len_phase && (r_pos == LAST_POS);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_DATA: begin
                if (finish) begin
                    n_state = FR_PAD;
                end
            end
            FR_PAD: begin
                if (last_pad) begin
                    n_state = FR_DATA;
                end
            end
            default: n_state = FR_DATA;
        endcase
    end

    // A word goes into the queue after its fourth byte.
    always_comb begin
        o_push          = byte_step && (r_pos[1:0] == LAST_LANE);
        o_entry.data    = word_next;
        o_entry.blk_end = (r_pos == LAST_POS);
        o_entry.digest  = last_pad;
    end

    // Control state: position, bit count and padding phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FR_DATA;
            r_pos       <= '0;
            r_bits      <= '0;
            r_first     <= 1'b0;
            r_len_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            if (byte_step) begin
                r_pos <= r_pos + 6'd1;
            end
            if (absorb) begin
                r_bits <= r_bits + 64'd8;
            end
            if (finish) begin
                r_bits  <= '0;
                r_first <= 1'b1;
            end
            if (pad_step) begin
                r_first <= 1'b0;
                if (last_pad) begin
                    r_len_phase <= 1'b0;
                end else if (!r_len_phase && (r_pos == LEN_START_POS - 6'd1)) begin
                    r_len_phase <= 1'b1;
                end
            end
        end
    end

    // Word assembly and the latched length, shifted out a byte at a time.
    always_ff @(posedge i_clk) begin
        if (byte_step) begin
            r_word <= word_next;
        end
        if (finish) begin
            r_len <= r_bits;
        end else if (pad_step && r_len_phase) begin
            r_len <= {8'h00, r_len[63:8]};
        end
    end

`ifndef SYNTHESIS
    // The digest marker only ever rides on the last word of a block.
    a_digest_on_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_entry.digest |-> o_entry.blk_end)
        else $error("digest marker on a word that does not end a block");

    // A finish request always leads into the padding tail.
    a_finish_pads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_state == FR_PAD) && r_first)
        else $error("finish accepted without starting the padding");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/md4_fifo.sv -----
`default_nettype none

module md4_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire md4_pkg::t_word_entry i_entry,
    output logic                      o_full,
    input  wire logic                 i_pop,
    output md4_pkg::t_word_entry      o_entry,
    output logic                      o_empty
);
    import md4_pkg::*;

    t_word_entry         r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    // Status and read port.
    always_comb begin
        o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
        o_empty = (r_count == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_entry = r_mem[r_rd];
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/md4_back.sv -----
`default_nettype none

module md4_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire md4_pkg::t_word_entry i_entry,
    input  wire logic                 i_empty,
    output logic                      o_pop,
    md4_out_if.source                 o_out
);
    import md4_pkg::*;

    t_back_state r_state, n_state;
    logic [3:0]  r_fill;
    logic [5:0]  r_step;
    logic        r_digest;
    logic [1:0]  r_emit_idx;
    logic [31:0] r_cv [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_buf [16];
    logic        r_o_valid;
    logic [31:0] r_o_word;
    logic [1:0]  r_o_idx;
    logic        r_o_last;

    logic [1:0]  rnd;
    logic [31:0] x_word;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] step_out;
    logic        out_free;
    logic        load_out;
    logic        start_run;

    // One compression step: add, then rotate left.
    always_comb begin
        rnd      = r_step[5:4];
        x_word   = r_buf[md4_word_idx(rnd, r_step[3:0])];
        sum      = r_a + md4_round_fn(rnd, r_b, r_c, r_d) + x_word + md4_round_k(rnd);
        rot_wide = {sum, sum} << md4_rot(rnd, r_step[1:0]);
        step_out = rot_wide[63:32];
    end

    // Control outputs of the sequencer.
    always_comb begin
        out_free  = !r_o_valid || o_out.ready;
        o_pop     = (r_state == BK_FILL) && !i_empty;
        start_run = o_pop && i_entry.blk_end;
        load_out  = (r_state == BK_EMIT) && out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_FILL: begin
                if (start_run) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (r_step == LAST_STEP) begin
                    n_state = BK_ADD;
                end
            end
            BK_ADD: n_state = r_digest ? BK_EMIT : BK_FILL;
            BK_EMIT: begin
                if (load_out && (r_emit_idx == LAST_DIGEST)) begin
                    n_state = BK_FILL;
                end
            end
            default: n_state = BK_FILL;
        endcase
    end

    // Control state and chaining value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_FILL;
            r_fill     <= '0;
            r_step     <= '0;
            r_digest   <= 1'b0;
            r_emit_idx <= '0;
            r_o_valid  <= 1'b0;
            r_cv[0]    <= IV_A;
            r_cv[1]    <= IV_B;
            r_cv[2]    <= IV_C;
            r_cv[3]    <= IV_D;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_fill   <= r_fill + 4'd1;
                r_digest <= i_entry.digest;
            end
            if (start_run) begin
                r_step <= '0;
            end else if (r_state == BK_RUN) begin
                r_step <= r_step + 6'd1;
            end
            if (r_state == BK_ADD) begin
                r_cv[0] <= r_cv[0] + r_a;
                r_cv[1] <= r_cv[1] + r_b;
                r_cv[2] <= r_cv[2] + r_c;
                r_cv[3] <= r_cv[3] + r_d;
            end
            if (load_out) begin
                r_emit_idx <= r_emit_idx + 2'd1;
                if (r_emit_idx == LAST_DIGEST) begin
                    r_cv[0] <= IV_A;
                    r_cv[1] <= IV_B;
                    r_cv[2] <= IV_C;
                    r_cv[3] <= IV_D;
                end
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Block buffer, working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_buf[r_fill] <= i_entry.data;
        end
        if (start_run) begin
            r_a <= r_cv[0];
            r_b <= r_cv[1];
            r_c <= r_cv[2];
            r_d <= r_cv[3];
        end else if (r_state == BK_RUN) begin
            r_a <= r_d;
            r_b <= step_out;
            r_c <= r_b;
            r_d <= r_c;
        end
        if (load_out) begin
            r_o_word <= r_cv[r_emit_idx];
            r_o_idx  <= r_emit_idx;
            r_o_last <= (r_emit_idx == LAST_DIGEST);
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.digest_word = r_o_word;
    assign o_out.word_index  = r_o_idx;
    assign o_out.last_word   = r_o_last;

`ifndef SYNTHESIS
    // The block-end marker and the fill counter must agree.
    a_block_end_at_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_entry.blk_end == (r_fill == LAST_WORD_POS)))
        else $error("block end marker out of step with the fill counter");

    // The step counter never runs past the last step of the third round.
    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RUN) |-> (r_step <= LAST_STEP))
        else $error("compression step counter out of range");

    // The final flag goes only with the fourth digest word.
    a_last_is_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_last == (r_o_idx == LAST_DIGEST)))
        else $error("last word flag does not match the word index");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/md4_message_digest.sv -----
// One byte word is taken per cycle while not padding and the four-word queue has room.
// The compressor loads 16 words, then runs 48 steps and a fold-in step; loading is
// paced by the byte input, and bytes keep filling the queue while a block is compressed.
// Finish appends 9 to 72 padding bytes; digest word A is valid once the last block
// has been compressed and folded in, then B, C and D follow one per cycle when taken.
// Synchronous active-low reset restores the chaining value and clears counts and queue.
`default_nettype none

module md4_message_digest (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    md4_in_if.sink    i_in,
    md4_out_if.source o_out
);
    import md4_pkg::*;

    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_word_entry push_entry;
    t_word_entry pop_entry;

    // Byte gathering and padding.
    md4_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // Word queue between the two parts.
    md4_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_empty (empty)
    );

    // Compression and digest output.
    md4_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (pop_entry),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- sim/md4_message_digest_test.sv -----
`timescale 1ns / 1ps

// One expected or observed digest word.
typedef struct packed {
    logic [31:0] word_value;
    logic [1:0]  word_slot;
    logic        is_last;
} t_digest_word;

// Tracks the running MD4 state of the message stream and checks the digest words.
class md4_digest_scoreboard;
    logic [31:0]  chain[4];
    logic [63:0]  msg_bits;
    logic [31:0]  blk[16];
    int unsigned  fill;
    t_digest_word pending_digest_words[$];
    int unsigned  failures;
    int unsigned  words_checked;
    int unsigned  messages;
    int unsigned  bytes_absorbed;

    function new();
        failures       = 0;
        words_checked  = 0;
        messages       = 0;
        bytes_absorbed = 0;
        foreach (blk[i]) blk[i] = '0;
        restart();
    endfunction

    // The chaining value, bit count and fill level return to their initial values.
    function void restart();
        chain[0] = md4_pkg::IV_A;
        chain[1] = md4_pkg::IV_B;
        chain[2] = md4_pkg::IV_C;
        chain[3] = md4_pkg::IV_D;
        msg_bits = '0;
        fill     = 0;
    endfunction

    function logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Left rotation of each step, by round and by lane within the group of four.
    function int unsigned shift_of(input int unsigned rnd, input int unsigned lane);
        case (rnd)
            0: return (lane == 0) ? 3 : (lane == 1) ? 7 : (lane == 2) ? 11 : 19;
            1: return (lane == 0) ? 3 : (lane == 1) ? 5 : (lane == 2) ? 9 : 13;
            default: return (lane == 0) ? 3 : (lane == 1) ? 9 : (lane == 2) ? 11 : 15;
        endcase
    endfunction

    // Forty-eight steps over the sixteen block words, then the fold into the chain.
    function void compress_block();
        logic [31:0]  r[4];
        logic [31:0]  b, c, d, f, k;
        logic [3:0]   s;
        logic [3:0]   idx;
        int unsigned  rnd;
        int unsigned  ia;
        for (int i = 0; i < 4; i++) r[i] = chain[i];
        for (int j = 0; j < 48; j++) begin
            rnd = j / 16;
            s   = 4'(j % 16);
            ia  = (4 - (j % 4)) % 4;
            b   = r[(ia + 1) % 4];
            c   = r[(ia + 2) % 4];
            d   = r[(ia + 3) % 4];
            case (rnd)
                0: begin
                    f   = (b & c) | (~b & d);
                    k   = 32'h0;
                    idx = s;
                end
                1: begin
                    f   = (b & c) | (b & d) | (c & d);
                    k   = 32'h5a827999;
                    idx = {s[1:0], 2'b00} + {2'b00, s[3:2]};
                end
                default: begin
                    f   = b ^ c ^ d;
                    k   = 32'h6ed9eba1;
                    idx = {s[0], s[1], s[2], s[3]};
                end
            endcase
            r[ia] = rotl(r[ia] + f + blk[idx] + k, shift_of(rnd, j % 4));
        end
        for (int i = 0; i < 4; i++) chain[i] = chain[i] + r[i];
    endfunction

    // Places a byte in the block, little-endian within each 32-bit word.
    function void absorb_byte(input logic [7:0] b);
        blk[fill / 4][8 * (fill % 4) +: 8] = b;
        fill++;
        if (fill == 64) begin
            compress_block();
            fill = 0;
        end
    endfunction

    // Pads the message, folds in the latched length and queues the four digest words.
    function void finish_message();
        logic [63:0]  len;
        t_digest_word dw;
        len = msg_bits;
        absorb_byte(md4_pkg::PAD_BYTE);
        while (fill != md4_pkg::LEN_START_POS) absorb_byte(8'h00);
        for (int i = 0; i < 8; i++) absorb_byte(len[8 * i +: 8]);
        for (int i = 0; i < 4; i++) begin
            dw.word_value = chain[i];
            dw.word_slot  = 2'(i);
            dw.is_last    = (dw.word_slot == md4_pkg::LAST_DIGEST);
            pending_digest_words.push_back(dw);
        end
        restart();
        messages++;
    endfunction

    // Called for each word accepted on the message channel.
    function void note_word(input logic action, input logic [7:0] msg_byte);
        if (action == 1'b0) begin
            msg_bits = msg_bits + 64'd8;
            absorb_byte(msg_byte);
            bytes_absorbed++;
        end else begin
            finish_message();
        end
    endfunction

    function void report_failure(input string what);
        if (failures < 10) $display("%s", what);
        failures++;
    endfunction

    // Called for each word accepted on the digest channel.
    function void check_word(input t_digest_word got);
        t_digest_word want;
        words_checked++;
        if (pending_digest_words.size() == 0) begin
            report_failure($sformatf("Unexpected digest word: slot %0d value %h last %b",
                                     got.word_slot, got.word_value, got.is_last));
        end else begin
            want = pending_digest_words.pop_front();
            if (want != got) begin
                report_failure($sformatf(
                    "Digest mismatch: expected slot %0d %h last %b, got slot %0d %h last %b",
                    want.word_slot, want.word_value, want.is_last,
                    got.word_slot, got.word_value, got.is_last));
            end
        end
    endfunction

    function int unsigned pending();
        return pending_digest_words.size();
    endfunction
endclass

module md4_message_digest_test;
    localparam int          CLK_PERIOD   = 10;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          TARGET_WORDS = 480;
    localparam int          MIN_DIGESTS  = 12;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic        ACT_ABSORB   = 1'b0;
    localparam logic        ACT_FINISH   = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    md4_in_if  msg_ch ();
    md4_out_if dig_ch ();

    md4_digest_scoreboard sb;
    int unsigned          cycle_count = 0;
    int unsigned          words_sent  = 0;
    bit                   send_burst  = 1'b0;
    bit                   sink_burst  = 1'b0;

    md4_message_digest uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (msg_ch),
        .o_out   (dig_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d digest words outstanding",
                     cycle_count, sb.pending());
            $display("[md4_message_digest] ERROR");
            $finish;
        end
    end

    // Every accepted digest word is checked against the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && dig_ch.valid && dig_ch.ready) begin
            sb.check_word('{word_value: dig_ch.digest_word, word_slot: dig_ch.word_index,
                            is_last: dig_ch.last_word});
        end
    end

    // The digest side stalls at random before each word, and not at all during bursts.
    initial begin
        int stall;
        dig_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                dig_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            dig_ch.ready = 1'b1;
            do @(posedge i_clk); while (!dig_ch.valid);
            @(negedge i_clk);
            if ($urandom_range(0, 15) == 0) sink_burst = ~sink_burst;
        end
    end

    // Sends one word after a random gap, none in bursts; entered and left just after a falling edge.
    task automatic send_word(input logic action, input logic [7:0] msg_byte);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            msg_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        msg_ch.valid        = 1'b1;
        msg_ch.action       = action;
        msg_ch.message_byte = msg_byte;
        do @(posedge i_clk); while (!msg_ch.ready);
        sb.note_word(action, msg_byte);
        words_sent++;
        @(negedge i_clk);
    endtask

    // A message of random bytes followed by a finish word carrying a random ignored byte.
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_word(ACT_ABSORB, 8'($urandom_range(0, 255)));
        send_word(ACT_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Mostly short messages, with lengths around the padding and block boundaries mixed in.
    function automatic int pick_length();
        int choice;
        choice = $urandom_range(0, 9);
        if (choice < 6) return $urandom_range(0, 20);
        case ($urandom_range(0, 8))
            0: return 55;
            1: return 56;
            2: return 57;
            3: return 63;
            4: return 64;
            5: return 65;
            6: return 119;
            7: return 120;
            default: return $urandom_range(21, 130);
        endcase
    endfunction

    initial begin
        sb                  = new();
        i_rst_n             = 1'b0;
        msg_ch.valid        = 1'b0;
        msg_ch.action       = ACT_ABSORB;
        msg_ch.message_byte = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty message whose finish word carries an all-ones byte.
        send_word(ACT_FINISH, 8'hff);
        // The classic three-letter message.
        send_word(ACT_ABSORB, 8'h61);
        send_word(ACT_ABSORB, 8'h62);
        send_word(ACT_ABSORB, 8'h63);
        send_word(ACT_FINISH, 8'h00);
        // Byte extremes, then a second empty message straight after.
        send_word(ACT_ABSORB, 8'h00);
        send_word(ACT_ABSORB, 8'hff);
        send_word(ACT_ABSORB, 8'h80);
        send_word(ACT_ABSORB, 8'h7f);
        send_word(ACT_FINISH, 8'h55);
        send_word(ACT_FINISH, 8'haa);

        // Random messages until enough words and digests have gone through.
        while (words_sent < TARGET_WORDS || sb.messages < MIN_DIGESTS) begin
            send_burst = ($urandom_range(0, 3) == 0);
            send_message(pick_length());
        end
        msg_ch.valid = 1'b0;

        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Hashed %0d messages from %0d message bytes in %0d input words.",
                 sb.messages, sb.bytes_absorbed, words_sent);
        $display("Checked %0d digest words; %0d failures.", sb.words_checked, sb.failures);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("[md4_message_digest] OK");
        end else begin
            $display("[md4_message_digest] ERROR");
        end
        $finish;
    end
endmodule
